/* rtl/core/ps_string_unescape_hex_core_assert.svh */
// Assertion macros for the string unescape core.
`ifndef PS_STRING_UNESCAPE_HEX_CORE_ASSERT_SVH
`define PS_STRING_UNESCAPE_HEX_CORE_ASSERT_SVH

// Same-cycle implication.
`define PSUH_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("psuh assertion failed");

// Next-cycle implication.
`define PSUH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("psuh assertion failed");

`endif

/* rtl/core/psuh_pkg.sv */
`default_nettype none

package psuh_pkg;

    localparam int MAX_FONTS  = 16;
    localparam int CHAR_CODES = 256;
    localparam int ADDR_W     = $clog2(CHAR_CODES);
    localparam int Q_DEPTH    = 2;

    localparam logic [7:0] CH_BACKSLASH = 8'd92;
    localparam logic [7:0] CH_LPAREN    = 8'd40;
    localparam logic [7:0] CH_RPAREN    = 8'd41;
    localparam logic [7:0] CH_ZERO      = 8'd48;
    localparam logic [7:0] CH_SEVEN     = 8'd55;
    localparam logic [7:0] CH_ALPHA_OFS = 8'd87;
    localparam logic [3:0] NIB_TEN      = 4'd10;

    typedef enum logic [1:0] {
        K_BYTE  = 2'd0,
        K_END   = 2'd1,
        K_QUERY = 2'd2
    } t_in_kind;

    typedef enum logic [1:0] {
        OK_HEX   = 2'd0,
        OK_END   = 2'd1,
        OK_QUERY = 2'd2
    } t_out_kind;

    typedef enum logic [1:0] {
        M_NORMAL = 2'd0,
        M_ESCAPE = 2'd1,
        M_OCTAL  = 2'd2
    } t_esc_mode;

    typedef enum logic [1:0] {
        B_NONE  = 2'd0,
        B_BYTE  = 2'd1,
        B_END   = 2'd2,
        B_QUERY = 2'd3
    } t_b_kind;

    typedef enum logic [2:0] {
        BS_CLEAR = 3'd0,
        BS_IDLE  = 3'd1,
        BS_A_HI  = 3'd2,
        BS_A_LO  = 3'd3,
        BS_B_HI  = 3'd4,
        BS_B_LO  = 3'd5,
        BS_B_ONE = 3'd6
    } t_bstate;

    // One classified transaction: optional flushed octal byte, then at most one trailing action.
    typedef struct packed {
        logic       has_a;
        logic [7:0] byte_a;
        t_b_kind    b_kind;
        logic [7:0] byte_b;
        logic [3:0] font;
    } t_cmd;

    typedef struct packed {
        logic valid;
        logic full;
    } t_q_status;

    typedef struct packed {
        logic clearing;
    } t_back_status;

    typedef logic [MAX_FONTS-1:0] t_row;

    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        return (nib < NIB_TEN) ? (CH_ZERO + {4'd0, nib}) : (CH_ALPHA_OFS + {4'd0, nib});
    endfunction

endpackage

`default_nettype wire

/* rtl/core/psuh_front.sv */
`default_nettype none

module psuh_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_accept,
    input  wire logic [1:0]     i_kind,
    input  wire logic [7:0]     i_data_byte,
    input  wire logic [3:0]     i_font_index,
    output logic                o_cmd_push,
    output psuh_pkg::t_cmd      o_cmd
);

    psuh_pkg::t_esc_mode r_mode, n_mode;
    logic [7:0]          r_acc, n_acc;
    logic [1:0]          r_cnt, n_cnt;

    logic       w_is_oct;
    logic       w_is_lit;
    logic       w_is_bs;
    logic [7:0] w_acc_shift;

    assign w_is_oct = i_data_byte inside {[psuh_pkg::CH_ZERO:psuh_pkg::CH_SEVEN]};
    assign w_is_lit = i_data_byte inside {psuh_pkg::CH_BACKSLASH, psuh_pkg::CH_LPAREN,
                                          psuh_pkg::CH_RPAREN};
    assign w_is_bs  = (i_data_byte == psuh_pkg::CH_BACKSLASH);
    assign w_acc_shift = {r_acc[4:0], i_data_byte[2:0]};

    // Next escape state
    always_comb begin
        n_mode = r_mode;
        n_acc  = r_acc;
        n_cnt  = r_cnt;
        if (i_accept) begin
            case (i_kind)
                psuh_pkg::K_BYTE: begin
                    case (r_mode)
                        psuh_pkg::M_ESCAPE: begin
                            if (w_is_oct && !w_is_lit) begin
                                n_acc  = {5'd0, i_data_byte[2:0]};
                                n_cnt  = 2'd1;
                                n_mode = psuh_pkg::M_OCTAL;
                            end else begin
                                n_mode = psuh_pkg::M_NORMAL;
                            end
                        end
                        psuh_pkg::M_OCTAL: begin
                            if (w_is_oct) begin
                                if (r_cnt == 2'd2) begin
                                    n_mode = psuh_pkg::M_NORMAL;
                                    n_acc  = 8'd0;
                                    n_cnt  = 2'd0;
                                end else begin
                                    n_acc  = w_acc_shift;
                                    n_cnt  = r_cnt + 2'd1;
                                end
                            end else begin
                                n_acc  = 8'd0;
                                n_cnt  = 2'd0;
                                n_mode = w_is_bs ? psuh_pkg::M_ESCAPE : psuh_pkg::M_NORMAL;
                            end
                        end
                        default: begin
                            n_mode = w_is_bs ? psuh_pkg::M_ESCAPE : psuh_pkg::M_NORMAL;
                        end
                    endcase
                end
                psuh_pkg::K_END: begin
                    n_mode = psuh_pkg::M_NORMAL;
                    n_acc  = 8'd0;
                    n_cnt  = 2'd0;
                end
                default: begin
                end
            endcase
        end
    end

    // Command formation
    always_comb begin
        o_cmd        = '0;
        o_cmd.byte_a = r_acc;
        o_cmd.byte_b = i_data_byte;
        o_cmd.font   = i_font_index;
        o_cmd.b_kind = psuh_pkg::B_NONE;
        case (i_kind)
            psuh_pkg::K_BYTE: begin
                case (r_mode)
                    psuh_pkg::M_ESCAPE: begin
                        if (!w_is_oct || w_is_lit) begin
                            o_cmd.b_kind = psuh_pkg::B_BYTE;
                        end
                    end
                    psuh_pkg::M_OCTAL: begin
                        if (w_is_oct) begin
                            if (r_cnt == 2'd2) begin
                                o_cmd.b_kind = psuh_pkg::B_BYTE;
                                o_cmd.byte_b = w_acc_shift;
                            end
                        end else begin
                            o_cmd.has_a = 1'b1;
                            if (!w_is_bs) begin
                                o_cmd.b_kind = psuh_pkg::B_BYTE;
                            end
                        end
                    end
                    default: begin
                        if (!w_is_bs) begin
                            o_cmd.b_kind = psuh_pkg::B_BYTE;
                        end
                    end
                endcase
            end
            psuh_pkg::K_END: begin
                o_cmd.has_a  = (r_mode == psuh_pkg::M_OCTAL);
                o_cmd.b_kind = psuh_pkg::B_END;
            end
            psuh_pkg::K_QUERY: begin
                o_cmd.b_kind = psuh_pkg::B_QUERY;
            end
            default: begin
            end
        endcase
    end

    assign o_cmd_push = i_accept && (o_cmd.has_a || (o_cmd.b_kind != psuh_pkg::B_NONE));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= psuh_pkg::M_NORMAL;
            r_acc  <= 8'd0;
            r_cnt  <= 2'd0;
        end else begin
            r_mode <= n_mode;
            r_acc  <= n_acc;
            r_cnt  <= n_cnt;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/psuh_cmdq.sv */
`default_nettype none

module psuh_cmdq (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_push,
    input  wire psuh_pkg::t_cmd      i_cmd,
    input  wire logic                i_pop,
    output psuh_pkg::t_cmd           o_cmd,
    output psuh_pkg::t_q_status      o_status
);

    localparam int PW = (psuh_pkg::Q_DEPTH > 1) ? $clog2(psuh_pkg::Q_DEPTH) : 1;
    localparam int CW = $clog2(psuh_pkg::Q_DEPTH + 1);

    psuh_pkg::t_cmd r_slot [psuh_pkg::Q_DEPTH];
    logic [PW-1:0]  r_wptr, n_wptr;
    logic [PW-1:0]  r_rptr, n_rptr;
    logic [CW-1:0]  r_count, n_count;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count + CW'(i_push) - CW'(i_pop);
        if (i_push) begin
            n_wptr = (r_wptr == PW'(psuh_pkg::Q_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (i_pop) begin
            n_rptr = (r_rptr == PW'(psuh_pkg::Q_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_cmd;
        end
    end

    assign o_cmd          = r_slot[r_rptr];
    assign o_status.valid = (r_count != '0);
    assign o_status.full  = (r_count == CW'(psuh_pkg::Q_DEPTH));

endmodule

`default_nettype wire

/* rtl/core/psuh_back.sv */
`default_nettype none

module psuh_back (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire psuh_pkg::t_q_status   i_q,
    input  wire psuh_pkg::t_cmd        i_cmd,
    output logic                       o_pop,
    input  wire logic                  i_out_pop,
    output psuh_pkg::t_back_status     o_status,
    output logic                       o_out_valid,
    output logic [1:0]                 o_out_kind,
    output logic [7:0]                 o_hex_char,
    output logic                       o_char_used,
    output logic                       o_last_of_run
);

    psuh_pkg::t_bstate            r_state, n_state;
    psuh_pkg::t_cmd               r_cmd;
    logic [psuh_pkg::ADDR_W-1:0]  r_clr_addr, n_clr_addr;
    psuh_pkg::t_row               r_mem [psuh_pkg::CHAR_CODES];
    psuh_pkg::t_row               r_row;

    logic                r_out_valid;
    psuh_pkg::t_out_kind r_out_kind;
    logic [7:0]          r_out_hex;
    logic                r_out_used;
    logic                r_out_last;

    logic                w_emitting;
    logic                w_adv;
    logic                w_done;
    logic                w_load;
    psuh_pkg::t_out_kind w_kind;
    logic [7:0]          w_hex;
    logic                w_used;
    logic                w_last;
    logic                w_mark_en;
    logic [7:0]          w_mark_byte;

    function automatic psuh_pkg::t_bstate first_state(input psuh_pkg::t_cmd c);
        if (c.has_a) begin
            return psuh_pkg::BS_A_HI;
        end else if (c.b_kind == psuh_pkg::B_BYTE) begin
            return psuh_pkg::BS_B_HI;
        end
        return psuh_pkg::BS_B_ONE;
    endfunction

    assign w_emitting = r_state inside {psuh_pkg::BS_A_HI, psuh_pkg::BS_A_LO, psuh_pkg::BS_B_HI,
                                        psuh_pkg::BS_B_LO, psuh_pkg::BS_B_ONE};
    assign w_adv  = w_emitting && (!r_out_valid || i_out_pop);
    assign w_done = w_adv && (((r_state == psuh_pkg::BS_A_LO) &&
                               (r_cmd.b_kind == psuh_pkg::B_NONE)) ||
                              (r_state == psuh_pkg::BS_B_LO) ||
                              (r_state == psuh_pkg::BS_B_ONE));
    assign w_load = i_q.valid && ((r_state == psuh_pkg::BS_IDLE) || w_done);

    // Next state
    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        case (r_state)
            psuh_pkg::BS_CLEAR: begin
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == psuh_pkg::ADDR_W'(psuh_pkg::CHAR_CODES - 1)) begin
                    n_state = psuh_pkg::BS_IDLE;
                end
            end
            psuh_pkg::BS_A_HI: begin
                if (w_adv) begin
                    n_state = psuh_pkg::BS_A_LO;
                end
            end
            psuh_pkg::BS_A_LO: begin
                if (w_adv) begin
                    case (r_cmd.b_kind)
                        psuh_pkg::B_BYTE: n_state = psuh_pkg::BS_B_HI;
                        psuh_pkg::B_NONE: n_state = psuh_pkg::BS_IDLE;
                        default:          n_state = psuh_pkg::BS_B_ONE;
                    endcase
                end
            end
            psuh_pkg::BS_B_HI: begin
                if (w_adv) begin
                    n_state = psuh_pkg::BS_B_LO;
                end
            end
            psuh_pkg::BS_B_LO, psuh_pkg::BS_B_ONE: begin
                if (w_adv) begin
                    n_state = psuh_pkg::BS_IDLE;
                end
            end
            default: begin
            end
        endcase
        if (w_load) begin
            n_state = first_state(i_cmd);
        end
    end

    // Outputs
    always_comb begin
        w_kind      = psuh_pkg::OK_HEX;
        w_hex       = 8'd0;
        w_used      = 1'b0;
        w_last      = 1'b0;
        w_mark_en   = 1'b0;
        w_mark_byte = r_cmd.byte_a;
        case (r_state)
            psuh_pkg::BS_A_HI: begin
                w_hex     = psuh_pkg::hex_digit(r_cmd.byte_a[7:4]);
                w_mark_en = w_adv;
            end
            psuh_pkg::BS_A_LO: begin
                w_hex  = psuh_pkg::hex_digit(r_cmd.byte_a[3:0]);
                w_last = (r_cmd.b_kind == psuh_pkg::B_NONE);
            end
            psuh_pkg::BS_B_HI: begin
                w_hex       = psuh_pkg::hex_digit(r_cmd.byte_b[7:4]);
                w_mark_en   = w_adv;
                w_mark_byte = r_cmd.byte_b;
            end
            psuh_pkg::BS_B_LO: begin
                w_hex  = psuh_pkg::hex_digit(r_cmd.byte_b[3:0]);
                w_last = 1'b1;
            end
            psuh_pkg::BS_B_ONE: begin
                w_last = 1'b1;
                if (r_cmd.b_kind == psuh_pkg::B_QUERY) begin
                    w_kind = psuh_pkg::OK_QUERY;
                    w_used = r_row[r_cmd.font];
                end else begin
                    w_kind = psuh_pkg::OK_END;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= psuh_pkg::BS_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_cmd <= i_cmd;
        end
        if (w_adv) begin
            r_out_kind <= w_kind;
            r_out_hex  <= w_hex;
            r_out_used <= w_used;
            r_out_last <= w_last;
        end
    end

    // Used-character memory: one row per character code, one bit per font
    always_ff @(posedge i_clk) begin
        if (r_state == psuh_pkg::BS_CLEAR) begin
            r_mem[r_clr_addr] <= '0;
        end else if (w_mark_en) begin
            r_mem[w_mark_byte][r_cmd.font] <= 1'b1;
        end
        if (w_load) begin
            r_row <= r_mem[i_cmd.byte_b];
        end
    end

    assign o_pop           = w_load;
    assign o_status.clearing = (r_state == psuh_pkg::BS_CLEAR);
    assign o_out_valid     = r_out_valid;
    assign o_out_kind      = r_out_kind;
    assign o_hex_char      = r_out_hex;
    assign o_char_used     = r_out_used;
    assign o_last_of_run   = r_out_last;

endmodule

`default_nettype wire

/* rtl/core/ps_string_unescape_hex_core.sv */
// Channel   Direction  Handshake              Payload
// input     in         push / full            i_kind, i_data_byte, i_font_index
// result    out        pop / empty            o_out_kind, o_hex_char, o_char_used,
//                                             o_last_of_run
//
// A decoded byte yields two results (one per hex digit); an octal flush plus a
// byte yields four, an end item one or three, a query one.
// Input is taken every cycle while the two-entry command queue has room and no clear runs.
// After reset, full stays high while the used-character memory is
// swept clear, one row per cycle.
// Stalls on pop hold the result register; the queue then fills and raises full.
`default_nettype none

module ps_string_unescape_hex_core (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic [1:0] i_kind,
    input  wire logic [7:0] i_data_byte,
    input  wire logic [3:0] i_font_index,
    output logic            empty,
    input  wire logic       pop,
    output logic [1:0]      o_out_kind,
    output logic [7:0]      o_hex_char,
    output logic            o_char_used,
    output logic            o_last_of_run
);

    `include "ps_string_unescape_hex_core_assert.svh"

    logic                   w_accept;
    logic                   w_cmd_push;
    psuh_pkg::t_cmd         w_cmd_in;
    psuh_pkg::t_cmd         w_cmd_head;
    psuh_pkg::t_q_status    w_qstat;
    psuh_pkg::t_back_status w_bstat;
    logic                   w_q_pop;
    logic                   w_out_valid;
    logic                   w_marker_out;

    assign full     = w_qstat.full || w_bstat.clearing;
    assign w_accept = push && !full;
    assign empty    = !w_out_valid;
    assign w_marker_out = !empty && (o_out_kind != psuh_pkg::OK_HEX);

    psuh_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (w_accept),
        .i_kind       (i_kind),
        .i_data_byte  (i_data_byte),
        .i_font_index (i_font_index),
        .o_cmd_push   (w_cmd_push),
        .o_cmd        (w_cmd_in)
    );

    psuh_cmdq u_cmdq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_cmd_push),
        .i_cmd    (w_cmd_in),
        .i_pop    (w_q_pop),
        .o_cmd    (w_cmd_head),
        .o_status (w_qstat)
    );

    psuh_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q           (w_qstat),
        .i_cmd         (w_cmd_head),
        .o_pop         (w_q_pop),
        .i_out_pop     (pop),
        .o_status      (w_bstat),
        .o_out_valid   (w_out_valid),
        .o_out_kind    (o_out_kind),
        .o_hex_char    (o_hex_char),
        .o_char_used   (o_char_used),
        .o_last_of_run (o_last_of_run)
    );

    `PSUH_ASSERT_IMPLIES(a_q_no_overflow, i_clk, i_rst_n, w_cmd_push, !w_qstat.full)
    `PSUH_ASSERT_IMPLIES(a_q_no_underflow, i_clk, i_rst_n, w_q_pop, w_qstat.valid)
    `PSUH_ASSERT_IMPLIES(a_marker_is_last, i_clk, i_rst_n, w_marker_out, o_last_of_run)
    `PSUH_ASSERT_NEXT(a_clear_once, i_clk, i_rst_n, !w_bstat.clearing, !w_bstat.clearing)

endmodule

`default_nettype wire

/* dv/ps_string_unescape_hex_core_checker.sv */
module ps_string_unescape_hex_core_checker (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_push,
    input  wire logic       i_full,
    input  wire logic [1:0] i_kind,
    input  wire logic [7:0] i_data_byte,
    input  wire logic [3:0] i_font_index,
    input  wire logic       i_empty,
    input  wire logic       i_pop,
    input  wire logic [1:0] i_out_kind,
    input  wire logic [7:0] i_hex_char,
    input  wire logic       i_char_used,
    input  wire logic       i_last_of_run,
    output int              o_fail_count,
    output int              o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [7:0] CH_LOWER_A = 8'h61;

    typedef struct packed {
        psuh_pkg::t_out_kind kind;
        logic [7:0]          hex;
        logic                used;
        logic                is_last;
    } t_result;

    t_result                         expected_q[$];
    t_result                         run_q[$];
    psuh_pkg::t_esc_mode             mode;
    logic [7:0]                      octal_acc;
    int                              octal_cnt;
    logic [psuh_pkg::CHAR_CODES-1:0] used_set [psuh_pkg::MAX_FONTS];
    int                              fail_count;

    function automatic logic [7:0] ascii_nibble(input logic [3:0] nib);
        return (nib < 4'd10) ? psuh_pkg::CH_ZERO + 8'(nib) : CH_LOWER_A + 8'(nib) - 8'd10;
    endfunction

    function automatic bit is_octal_digit(input logic [7:0] c);
        return (c >= psuh_pkg::CH_ZERO) && (c <= psuh_pkg::CH_SEVEN);
    endfunction

    function automatic void add_result(input psuh_pkg::t_out_kind k, input logic [7:0] hex,
                                       input logic used);
        t_result r;
        r.kind    = k;
        r.hex     = hex;
        r.used    = used;
        r.is_last = 1'b0;
        run_q = {run_q, r};
    endfunction

    function automatic void emit_decoded(input logic [7:0] b, input logic [3:0] font);
        if (int'(font) < psuh_pkg::MAX_FONTS)
            used_set[font][b] = 1'b1;
        add_result(psuh_pkg::OK_HEX, ascii_nibble(b[7:4]), 1'b0);
        add_result(psuh_pkg::OK_HEX, ascii_nibble(b[3:0]), 1'b0);
    endfunction

    function automatic void clear_octal();
        mode      = psuh_pkg::M_NORMAL;
        octal_acc = '0;
        octal_cnt = 0;
    endfunction

    function automatic void take_plain(input logic [7:0] c, input logic [3:0] font);
        if (c == psuh_pkg::CH_BACKSLASH)
            mode = psuh_pkg::M_ESCAPE;
        else
            emit_decoded(c, font);
    endfunction

    function automatic void predict_item(input logic [1:0] k, input logic [7:0] c,
                                         input logic [3:0] font);
        t_result tail;
        logic    bit_val;
        run_q.delete();
        case (k)
            psuh_pkg::K_BYTE: begin
                case (mode)
                    psuh_pkg::M_ESCAPE: begin
                        if (c == psuh_pkg::CH_BACKSLASH || c == psuh_pkg::CH_LPAREN ||
                            c == psuh_pkg::CH_RPAREN) begin
                            emit_decoded(c, font);
                            mode = psuh_pkg::M_NORMAL;
                        end else if (is_octal_digit(c)) begin
                            octal_acc = c - psuh_pkg::CH_ZERO;
                            octal_cnt = 1;
                            mode      = psuh_pkg::M_OCTAL;
                        end else begin
                            mode = psuh_pkg::M_NORMAL;
                            emit_decoded(c, font);
                        end
                    end
                    psuh_pkg::M_OCTAL: begin
                        if (is_octal_digit(c) && octal_cnt < 3) begin
                            octal_acc = {octal_acc[4:0], 3'b000} + (c - psuh_pkg::CH_ZERO);
                            octal_cnt++;
                            if (octal_cnt >= 3) begin
                                emit_decoded(octal_acc, font);
                                clear_octal();
                            end
                        end else begin
                            emit_decoded(octal_acc, font);
                            clear_octal();
                            take_plain(c, font);
                        end
                    end
                    default: begin
                        mode = psuh_pkg::M_NORMAL;
                        take_plain(c, font);
                    end
                endcase
            end
            psuh_pkg::K_END: begin
                if (mode == psuh_pkg::M_OCTAL)
                    emit_decoded(octal_acc, font);
                clear_octal();
                add_result(psuh_pkg::OK_END, 8'd0, 1'b0);
            end
            psuh_pkg::K_QUERY: begin
                bit_val = 1'b0;
                if (int'(font) < psuh_pkg::MAX_FONTS)
                    bit_val = used_set[font][c];
                add_result(psuh_pkg::OK_QUERY, 8'd0, bit_val);
            end
            default: ;
        endcase
        if (run_q.size() > 0) begin
            tail = run_q[run_q.size() - 1];
            tail.is_last = 1'b1;
            run_q[run_q.size() - 1] = tail;
        end
        expected_q = {expected_q, run_q};
    endfunction

    function automatic void check_field(input string name, input logic [7:0] exp_v,
                                        input logic [7:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_result exp_r;
        if (!i_rst_n) begin
            expected_q.delete();
            clear_octal();
            for (int f = 0; f < psuh_pkg::MAX_FONTS; f++)
                used_set[f] = '0;
            fail_count = 0;
        end else begin
            if (i_pop && !i_empty) begin
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected transaction: expected none, %s %0d %0d %0d %0d",
                             $time, "actual kind/hex/used/last", i_out_kind, i_hex_char,
                             i_char_used, i_last_of_run);
                    fail_count++;
                end else begin
                    exp_r = expected_q[0];
                    expected_q.delete(0);
                    check_field("out_kind", 8'(exp_r.kind), 8'(i_out_kind));
                    check_field("hex_char", exp_r.hex, i_hex_char);
                    check_field("char_used", 8'(exp_r.used), 8'(i_char_used));
                    check_field("last_of_run", 8'(exp_r.is_last), 8'(i_last_of_run));
                end
            end
            if (i_push && !i_full)
                predict_item(i_kind, i_data_byte, i_font_index);
        end
        o_pending    <= expected_q.size();
        o_fail_count <= fail_count;
    end

endmodule

/* dv/ps_string_unescape_hex_core_tb.sv */
module ps_string_unescape_hex_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] KIND_RESERVED = 2'd3;
    localparam int         LIMIT_CYCLES  = 200000;
    localparam int         TAIL_CYCLES   = 20;

    logic       clk;
    logic       rst_n;
    logic       push;
    logic       full;
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic [3:0] font_index;
    logic       empty;
    logic       pop = 1'b0;
    logic [1:0] out_kind;
    logic [7:0] hex_char;
    logic       char_used;
    logic       last_of_run;
    int         fail_count;
    int         pending;

    int         items_sent;
    int         random_base;
    int         send_idle_pct = 29;
    int         recv_idle_pct = 50;
    int         cycles = 0;
    logic [7:0] seen_codes[$];

    ps_string_unescape_hex_core u_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .push          (push),
        .full          (full),
        .i_kind        (kind),
        .i_data_byte   (data_byte),
        .i_font_index  (font_index),
        .empty         (empty),
        .pop           (pop),
        .o_out_kind    (out_kind),
        .o_hex_char    (hex_char),
        .o_char_used   (char_used),
        .o_last_of_run (last_of_run)
    );

    ps_string_unescape_hex_core_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_push        (push),
        .i_full        (full),
        .i_kind        (kind),
        .i_data_byte   (data_byte),
        .i_font_index  (font_index),
        .i_empty       (empty),
        .i_pop         (pop),
        .i_out_kind    (out_kind),
        .i_hex_char    (hex_char),
        .i_char_used   (char_used),
        .i_last_of_run (last_of_run),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    always begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    always @(negedge clk) begin
        pop <= rst_n && ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("ps_string_unescape_hex_core_tb failed");
            $finish;
        end
    end

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic send_item(input logic [1:0] k, input logic [7:0] d, input logic [3:0] f);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(negedge clk);
        end
        push       <= 1'b1;
        kind       <= k;
        data_byte  <= d;
        font_index <= f;
        do @(posedge clk); while (full);
        @(negedge clk);
        if (k != KIND_RESERVED)
            items_sent++;
    endtask

    task automatic send_byte(input logic [7:0] d, input logic [3:0] f);
        send_item(psuh_pkg::K_BYTE, d, f);
        seen_codes = {seen_codes, d};
        if (seen_codes.size() > 16)
            seen_codes.delete(0);
    endtask

    task automatic drain();
        push <= 1'b0;
        do @(posedge clk); while (pending != 0);
        @(negedge clk);
    endtask

    task automatic send_query(input logic [3:0] f);
        logic [7:0] code;
        if (seen_codes.size() > 0 && $urandom_range(1) == 0)
            code = seen_codes[$urandom_range(seen_codes.size() - 1)];
        else
            code = 8'($urandom_range(255));
        send_item(psuh_pkg::K_QUERY, code, f);
    endtask

    task automatic random_string();
        logic [3:0] f;
        int         n;
        int         r;
        int         digits;
        f = ($urandom_range(7) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(3));
        n = $urandom_range(8, 1);
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            if (r < 45) begin
                send_byte(8'($urandom_range(255)), f);
            end else if (r < 55) begin
                send_byte(psuh_pkg::CH_BACKSLASH, f);
                case ($urandom_range(2))
                    0:       send_byte(psuh_pkg::CH_BACKSLASH, f);
                    1:       send_byte(psuh_pkg::CH_LPAREN, f);
                    default: send_byte(psuh_pkg::CH_RPAREN, f);
                endcase
            end else if (r < 75) begin
                send_byte(psuh_pkg::CH_BACKSLASH, f);
                digits = $urandom_range(3, 1);
                for (int j = 0; j < digits; j++)
                    send_byte(psuh_pkg::CH_ZERO + 8'($urandom_range(7)), f);
            end else if (r < 85) begin
                send_byte(psuh_pkg::CH_BACKSLASH, f);
                if ($urandom_range(1) == 0)
                    send_byte(psuh_pkg::CH_ZERO + 8'($urandom_range(9, 8)), f);
                else
                    send_byte(8'($urandom_range(255)), f);
            end else if (r < 93) begin
                send_query(($urandom_range(3) == 0) ? 4'($urandom_range(15)) : f);
            end else begin
                send_item(KIND_RESERVED, 8'($urandom_range(255)), 4'($urandom_range(15)));
            end
        end
        if ($urandom_range(99) < 85)
            send_item(psuh_pkg::K_END, 8'($urandom_range(255)), f);
    endtask

    task automatic random_phase(input int count);
        random_base = items_sent;
        while (items_sent < random_base + count)
            random_string();
    endtask

    initial begin
        rst_n         = 1'b0;
        push          = 1'b0;
        kind          = psuh_pkg::K_BYTE;
        data_byte     = '0;
        font_index    = '0;
        items_sent    = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_item(psuh_pkg::K_QUERY, 8'h41, 4'd0);
        send_byte(8'h41, 4'd0);
        send_byte(8'h00, 4'd0);
        send_byte(8'hff, 4'd15);
        send_item(psuh_pkg::K_QUERY, 8'hff, 4'd15);
        send_byte(psuh_pkg::CH_BACKSLASH, 4'd1);
        send_byte(psuh_pkg::CH_BACKSLASH, 4'd1);
        send_byte(psuh_pkg::CH_BACKSLASH, 4'd1);
        send_item(KIND_RESERVED, 8'hff, 4'd15);
        send_byte(psuh_pkg::CH_LPAREN, 4'd1);
        send_byte(psuh_pkg::CH_BACKSLASH, 4'd2);
        send_byte(psuh_pkg::CH_RPAREN, 4'd2);
        // three digits, value truncated to 8 bits
        send_byte(psuh_pkg::CH_BACKSLASH, 4'd3);
        send_byte(psuh_pkg::CH_ZERO + 8'd7, 4'd3);
        send_byte(psuh_pkg::CH_ZERO + 8'd7, 4'd3);
        send_byte(psuh_pkg::CH_ZERO + 8'd7, 4'd3);
        send_byte(psuh_pkg::CH_BACKSLASH, 4'd4);
        send_byte(psuh_pkg::CH_ZERO + 8'd4, 4'd4);
        send_byte(psuh_pkg::CH_ZERO + 8'd9, 4'd5);
        send_byte(psuh_pkg::CH_BACKSLASH, 4'd6);
        send_byte(psuh_pkg::CH_ZERO + 8'd5, 4'd6);
        send_byte(psuh_pkg::CH_BACKSLASH, 4'd7);
        send_byte(psuh_pkg::CH_ZERO + 8'd8, 4'd7);
        send_byte(psuh_pkg::CH_BACKSLASH, 4'd8);
        send_byte(psuh_pkg::CH_ZERO + 8'd6, 4'd8);
        send_item(psuh_pkg::K_END, 8'h00, 4'd9);
        send_byte(psuh_pkg::CH_BACKSLASH, 4'd10);
        send_item(psuh_pkg::K_END, 8'hff, 4'd10);
        drain();

        random_phase(30);
        drain();
        send_idle_pct = 50;
        recv_idle_pct = 29;
        random_phase(30);
        drain();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(28);
        drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("ps_string_unescape_hex_core_tb passed");
        else
            $display("ps_string_unescape_hex_core_tb failed");
        $finish;
    end

endmodule
